// ===== design/interval_union_gap_table_defines.svh =====
// Assertion macros for the interval union gap table.
// Used by the datapath; compiled away when SYNTHESIS is defined.
`ifndef INTERVAL_UNION_GAP_TABLE_DEFINES_SVH
`define INTERVAL_UNION_GAP_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
`define IUGT_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
`define IUGT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define IUGT_ASSERT(lbl, clk, rst, prop)
`define IUGT_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== design/iugt_pkg.sv =====
// Shared constants, codes and controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps
package iugt_pkg;
  localparam int MAX_RANGES_DEF = 32;
  localparam int POS_BITS_DEF   = 24;
  localparam int GLEN_W         = 25;
  localparam int SUM_W          = 40;
  localparam logic [GLEN_W-1:0] GLEN_RESET = 25'd16777216;
  localparam logic REG_GLEN = 1'b0;

  typedef enum logic [1:0] {
    OP_ANNOUNCE = 2'd0,
    OP_EMIT     = 2'd1,
    OP_CLEAR    = 2'd2,
    OP_NOP      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_ILLEGAL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    SEL_RESP  = 2'd0,
    SEL_PEND  = 2'd1,
    SEL_FINAL = 2'd2
  } out_sel_t;

  typedef struct packed {
    logic     load;
    logic     st_we;
    status_t  st_val;
    logic     a_copy;
    logic     a_place;
    logic     a_merge;
    logic     e_step;
    logic     commit;
    logic     pend_clr;
    logic     out_load;
    out_sel_t out_sel;
    logic     out_last;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic done;
    logic illegal;
    logic below;
    logic after;
    logic gap_hit;
    logic fin_gap;
    logic have_pend;
    logic placed;
    logic full;
    logic out_free;
  } sts_t;
endpackage

// ===== design/iugt_if.sv =====
// Valid/ready channel interfaces for input and result beats.
// Depends on nothing.
`timescale 1ns / 1ps
interface iugt_in_if #(parameter int POS_BITS = 24);
  logic                valid;
  logic                ready;
  logic [1:0]          opcode;
  logic [POS_BITS-1:0] range_begin;
  logic [POS_BITS-1:0] range_end;
  modport source (output valid, opcode, range_begin, range_end, input ready);
  modport sink (input valid, opcode, range_begin, range_end, output ready);
endinterface

interface iugt_out_if #(parameter int POS_BITS = 24, parameter int CNT_W = 6);
  logic                valid;
  logic                ready;
  logic [POS_BITS-1:0] gap_begin;
  logic [POS_BITS-1:0] gap_end;
  logic                gap_valid;
  logic                last;
  logic [1:0]          status;
  logic [39:0]         overlap_total;
  logic [CNT_W-1:0]    range_count;
  modport source (output valid, gap_begin, gap_end, gap_valid, last, status,
                  overlap_total, range_count, input ready);
  modport sink (input valid, gap_begin, gap_end, gap_valid, last, status,
                overlap_total, range_count, output ready);
endinterface

// ===== design/interval_union_gap_table.sv =====
// Announce: walks the stored ranges through one bank's read port, copying them
// to the other bank, merging overlaps and inserting the new range in order.
// Emit: sends each gap of the table, waiting while results stall. Clear and
// no-op: one response beat. One item at a time; results leave via a register.
// Reset (synchronous): empty table, zero total, genome length 16777216.
`timescale 1ns / 1ps
module interval_union_gap_table import iugt_pkg::*; #(
  parameter int MAX_RANGES = MAX_RANGES_DEF,
  parameter int POS_BITS   = POS_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  iugt_in_if.sink     in_ch,
  iugt_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int EW = (GLEN_W > POS_BITS + 1) ? GLEN_W : POS_BITS + 1;

  logic [GLEN_W-1:0]   glen;
  logic [EW-1:0]       glen_ext, lim, eff;
  logic [POS_BITS-1:0] top;
  cmd_t                cmd;
  sts_t                sts;
  logic                ready;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_GLEN) ? 32'(glen) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      glen <= GLEN_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_GLEN) begin
      glen <= pwdata[GLEN_W-1:0];
    end
  end

  assign glen_ext = EW'(glen);
  assign lim = EW'(1) << POS_BITS;
  assign eff = (glen == '0) ? EW'(1) : ((glen_ext > lim) ? lim : glen_ext);
  assign top = POS_BITS'(eff - EW'(1));

  assign in_ch.ready = ready;

  iugt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(ready),
    .sts(sts), .cmd(cmd)
  );

  iugt_datapath #(.MAX_RANGES(MAX_RANGES), .POS_BITS(POS_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .opcode(in_ch.opcode), .range_begin(in_ch.range_begin),
    .range_end(in_ch.range_end), .top(top),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .gap_begin(out_ch.gap_begin), .gap_end(out_ch.gap_end),
    .gap_valid(out_ch.gap_valid), .last(out_ch.last), .status(out_ch.status),
    .overlap_total(out_ch.overlap_total), .range_count(out_ch.range_count)
  );
endmodule

// ===== design/iugt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module iugt_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== design/iugt_ctrl.sv =====
// Controller state machine: sequences announce, emit and response beats.
// Depends on iugt_pkg.
`timescale 1ns / 1ps
module iugt_ctrl import iugt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_CHK  = 7'b0000010,
    S_RD   = 7'b0000100,
    S_EVAL = 7'b0001000,
    S_ENDA = 7'b0010000,
    S_ENDE = 7'b0100000,
    S_RESP = 7'b1000000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd = '0;
    cmd.st_val = ST_OK;
    cmd.out_sel = SEL_RESP;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        case (sts.op)
          OP_ANNOUNCE: begin
            if (sts.illegal) begin
              cmd.st_we = 1'b1;
              cmd.st_val = ST_ILLEGAL;
              state_next = S_RESP;
            end else begin
              state_next = S_RD;
            end
          end
          OP_EMIT: state_next = S_RD;
          default: state_next = S_RESP;
        endcase
      end
      S_RD: begin
        if (sts.done) begin
          state_next = (sts.op == OP_EMIT) ? S_ENDE : S_ENDA;
        end else begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts.op == OP_EMIT) begin
          if (!(sts.gap_hit && sts.have_pend && !sts.out_free)) begin
            cmd.e_step = 1'b1;
            if (sts.gap_hit && sts.have_pend) begin
              cmd.out_load = 1'b1;
              cmd.out_sel = SEL_PEND;
            end
            state_next = S_RD;
          end
        end else if (sts.below) begin
          cmd.a_copy = 1'b1;
          state_next = S_RD;
        end else if (sts.after && !sts.placed) begin
          if (sts.full) begin
            cmd.st_we = 1'b1;
            cmd.st_val = ST_FULL;
            state_next = S_RESP;
          end else begin
            cmd.a_place = 1'b1;
          end
        end else if (sts.after) begin
          cmd.a_copy = 1'b1;
          state_next = S_RD;
        end else begin
          cmd.a_merge = 1'b1;
          state_next = S_RD;
        end
      end
      S_ENDA: begin
        if (sts.placed) begin
          cmd.commit = 1'b1;
        end else if (sts.full) begin
          cmd.st_we = 1'b1;
          cmd.st_val = ST_FULL;
        end else begin
          cmd.a_place = 1'b1;
          cmd.commit = 1'b1;
        end
        state_next = S_RESP;
      end
      S_ENDE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (sts.have_pend) begin
            cmd.out_sel = SEL_PEND;
            cmd.out_last = !sts.fin_gap;
            cmd.pend_clr = 1'b1;
            if (!sts.fin_gap) state_next = S_IDLE;
          end else if (sts.fin_gap) begin
            cmd.out_sel = SEL_FINAL;
            cmd.out_last = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd.out_last = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

// ===== design/iugt_datapath.sv =====
// Datapath: two range table banks, merge and gap logic, overlap total,
// result register. Depends on iugt_pkg, iugt_ram and the assertion macros.
`timescale 1ns / 1ps
`include "interval_union_gap_table_defines.svh"
module iugt_datapath import iugt_pkg::*; #(
  parameter int MAX_RANGES = MAX_RANGES_DEF,
  parameter int POS_BITS   = POS_BITS_DEF,
  localparam int CW = $clog2(MAX_RANGES + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  logic [1:0]          opcode,
  input  logic [POS_BITS-1:0] range_begin,
  input  logic [POS_BITS-1:0] range_end,
  input  logic [POS_BITS-1:0] top,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [POS_BITS-1:0] gap_begin,
  output logic [POS_BITS-1:0] gap_end,
  output logic                gap_valid,
  output logic                last,
  output logic [1:0]          status,
  output logic [SUM_W-1:0]    overlap_total,
  output logic [CW-1:0]       range_count
);
  localparam int AW = $clog2(MAX_RANGES);
  localparam int DW = 2 * POS_BITS;
  localparam int PW = POS_BITS + 1;

  op_t                op;
  logic [POS_BITS-1:0] b, e, nb, ne, pend_b, pend_e;
  logic [CW-1:0]       idx, widx, count;
  logic                placed, have_pend, bank;
  logic [PW-1:0]       cursor;
  status_t             st;
  logic [SUM_W-1:0]    ovsum;

  logic [DW-1:0]       rdata0, rdata1, entry, wdata;
  logic                we;
  logic [POS_BITS-1:0] eb, ee, eb_m1, gap_e, lo, hi;
  logic [PW-1:0]       ee_p1, amt;
  logic [SUM_W:0]      sum_ext;

  assign entry = bank ? rdata1 : rdata0;
  assign eb = entry[DW-1:POS_BITS];
  assign ee = entry[POS_BITS-1:0];
  assign we = cmd.a_copy | (cmd.a_place & (widx != CW'(MAX_RANGES)));
  assign wdata = cmd.a_place ? {nb, ne} : entry;

  iugt_ram #(.WIDTH(DW), .DEPTH(MAX_RANGES)) u_bank0 (
    .clk(clk), .we(we & bank), .waddr(widx[AW-1:0]), .wdata(wdata),
    .raddr(idx[AW-1:0]), .rdata(rdata0)
  );
  iugt_ram #(.WIDTH(DW), .DEPTH(MAX_RANGES)) u_bank1 (
    .clk(clk), .we(we & ~bank), .waddr(widx[AW-1:0]), .wdata(wdata),
    .raddr(idx[AW-1:0]), .rdata(rdata1)
  );

  assign eb_m1 = eb - POS_BITS'(1);
  assign gap_e = (eb_m1 > top) ? top : eb_m1;
  assign ee_p1 = {1'b0, ee} + PW'(1);
  assign lo = (eb > b) ? eb : b;
  assign hi = (ee < e) ? ee : e;
  assign amt = {1'b0, hi} - {1'b0, lo} + PW'(1);
  assign sum_ext = {1'b0, ovsum} + (SUM_W + 1)'(amt);

  always_comb begin
    sts.op        = op;
    sts.done      = (idx == count);
    sts.illegal   = (b > e) || (e > top);
    sts.below     = (ee < b);
    sts.after     = (eb > e);
    sts.fin_gap   = (cursor <= {1'b0, top});
    sts.gap_hit   = ({1'b0, eb} > cursor) && (cursor <= {1'b0, top});
    sts.have_pend = have_pend;
    sts.placed    = placed;
    sts.full      = (count == CW'(MAX_RANGES)) && (widx == idx);
    sts.out_free  = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank <= 1'b0;
      count <= '0;
      ovsum <= '0;
      out_valid <= 1'b0;
      placed <= 1'b0;
      have_pend <= 1'b0;
      idx <= '0;
      widx <= '0;
      op <= OP_NOP;
      st <= ST_OK;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.load) begin
        op <= op_t'(opcode);
        b <= range_begin;
        e <= range_end;
        nb <= range_begin;
        ne <= range_end;
        idx <= '0;
        widx <= '0;
        placed <= 1'b0;
        have_pend <= 1'b0;
        cursor <= '0;
        st <= ST_OK;
        if (op_t'(opcode) == OP_CLEAR) begin
          count <= '0;
          ovsum <= '0;
        end
      end
      if (cmd.st_we) st <= cmd.st_val;
      if (cmd.a_copy) begin
        widx <= widx + CW'(1);
        idx <= idx + CW'(1);
      end
      if (cmd.a_place) begin
        widx <= widx + CW'(1);
        placed <= 1'b1;
      end
      if (cmd.a_merge) begin
        ovsum <= sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
        if (eb < nb) nb <= eb;
        if (ee > ne) ne <= ee;
        idx <= idx + CW'(1);
      end
      if (cmd.e_step) begin
        if (sts.gap_hit) begin
          pend_b <= cursor[POS_BITS-1:0];
          pend_e <= gap_e;
          have_pend <= 1'b1;
        end
        if (ee_p1 > cursor) cursor <= ee_p1;
        idx <= idx + CW'(1);
      end
      if (cmd.pend_clr) have_pend <= 1'b0;
      if (cmd.commit) begin
        bank <= ~bank;
        count <= widx + CW'(we);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
        last <= cmd.out_last;
        overlap_total <= ovsum;
        range_count <= count;
        case (cmd.out_sel)
          SEL_PEND: begin
            gap_begin <= pend_b;
            gap_end <= pend_e;
            gap_valid <= 1'b1;
            status <= ST_OK;
          end
          SEL_FINAL: begin
            gap_begin <= cursor[POS_BITS-1:0];
            gap_end <= top;
            gap_valid <= 1'b1;
            status <= ST_OK;
          end
          default: begin
            gap_begin <= '0;
            gap_end <= '0;
            gap_valid <= 1'b0;
            status <= st;
          end
        endcase
      end
    end
  end

  `IUGT_ASSERT(a_count_bound, clk, rst, count <= CW'(MAX_RANGES))
  `IUGT_ASSERT_NEXT(a_commit_flip, clk, rst, cmd.commit, bank != $past(bank))
  `IUGT_ASSERT(a_gap_ok, clk, rst, !(out_valid && gap_valid) || (status == ST_OK && gap_begin <= gap_end))
endmodule
